### rtl/core/ecd_pkg.sv
// Shared constants, types and tables for the epoch seconds to civil date unit.
package ecd_pkg;

    // Pipeline depth and the role of each register stage.
    localparam int NUM_STAGES = 10;
    localparam int STG_BIAS   = 0;   // seconds biased to a non-negative value
    localparam int STG_RECIP  = 1;   // reciprocal product for the day estimate
    localparam int STG_DAY    = 2;   // corrected day number and second of day
    localparam int STG_ERA    = 3;   // era split, hour estimate
    localparam int STG_LEAP   = 4;   // leap corrections, minute remainder
    localparam int STG_TRUE   = 5;   // leap-free day of era, minute
    localparam int STG_YOE    = 6;   // year of era, second
    localparam int STG_DOY    = 7;   // day of year, full year
    localparam int STG_MONTH  = 8;   // March-based month index
    localparam int STG_OUT    = 9;   // output register

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    // Field widths of the result.
    localparam int YEAR_W   = 11;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // Internal widths.
    localparam int DNUM_W = 16;   // biased day number, 0..49711
    localparam int SOD_W  = 17;   // second of day, 0..86399
    localparam int DOE_W  = 18;   // day of era, 0..146096

    // Seconds bias: 24856 whole days, enough to lift any 32-bit input above zero.
    localparam logic [32:0] SEC_BIAS    = 33'd2147558400;
    // 86400 = 128 * 675; floor(2^35 / 675) gives an estimate low by at most one.
    localparam logic [25:0] RECIP_675   = 26'd50903316;
    localparam logic [25:0] DIV_675     = 26'd675;
    localparam logic [10:0] DIV_675_REM = 11'd675;

    // Biased day number to day count from 0000-03-01.
    localparam logic [19:0] DNUM_OFFSET = 20'd694612;
    localparam logic [19:0] ERA4_START  = 20'd584388;
    localparam logic [19:0] ERA5_START  = 20'd730485;
    localparam logic [11:0] ERA4_YEAR   = 12'd1600;
    localparam logic [11:0] ERA5_YEAR   = 12'd2000;

    // Century boundaries inside an era.
    localparam logic [DOE_W-1:0] CENT_1    = 18'd36524;
    localparam logic [DOE_W-1:0] CENT_2    = 18'd73048;
    localparam logic [DOE_W-1:0] CENT_3    = 18'd109572;
    localparam logic [DOE_W-1:0] ERA_LAST  = 18'd146096;

    // ceil(2^26 / 365), exact for every dividend below 2^18.
    localparam logic [17:0] RECIP_365     = 18'd183860;
    localparam logic [17:0] DAYS_PER_YEAR = 18'd365;
    // ceil(2^20 / 153), exact for dividends up to 1827.
    localparam logic [12:0] RECIP_153     = 13'd6854;

    // ceil(2^27 / 3600) and ceil(2^17 / 60), exact over their ranges.
    localparam logic [15:0] RECIP_3600    = 16'd37283;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] RECIP_60      = 12'd2185;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_hms;

    // First day of each March-based month within the shifted year.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/ecd_day_split.sv
// Floor division of signed epoch seconds into a biased day number and second of day.
module ecd_day_split (
    input  logic                           i_clk,
    input  ecd_pkg::t_stage_en             i_en,
    input  logic [31:0]                    i_secs,
    output logic [ecd_pkg::DNUM_W-1:0]     o_dnum,
    output logic [ecd_pkg::SOD_W-1:0]      o_sod
);
    import ecd_pkg::*;

    logic [32:0]       r_u_s0;
    logic [DNUM_W-1:0] r_q0_s1;
    logic [25:0]       r_v_s1;
    logic [6:0]        r_lo_s1;
    logic [DNUM_W-1:0] r_dnum_s2;
    logic [SOD_W-1:0]  r_sod_s2;

    logic [32:0] n_u;
    logic [51:0] w_prod;
    logic [25:0] w_mul;
    logic [10:0] w_rem;
    logic        w_fix;
    logic [10:0] w_rem_fix;

    // Bias keeps the dividend non-negative so plain division acts as floor.
    assign n_u    = {i_secs[31], i_secs} + SEC_BIAS;
    assign w_prod = 52'(r_u_s0[32:7]) * 52'(RECIP_675);

    assign w_mul     = 26'(r_q0_s1) * DIV_675;
    assign w_rem     = 11'(r_v_s1 - w_mul);
    assign w_fix     = (w_rem >= DIV_675_REM);
    assign w_rem_fix = w_fix ? (w_rem - DIV_675_REM) : w_rem;

    always_ff @(posedge i_clk) begin
        if (i_en[STG_BIAS]) begin
            r_u_s0 <= n_u;
        end
        if (i_en[STG_RECIP]) begin
            r_q0_s1 <= w_prod[50:35];
            r_v_s1  <= r_u_s0[32:7];
            r_lo_s1 <= r_u_s0[6:0];
        end
        if (i_en[STG_DAY]) begin
            r_dnum_s2 <= r_q0_s1 + DNUM_W'(w_fix);
            r_sod_s2  <= {w_rem_fix[9:0], r_lo_s1};
        end
    end

    assign o_dnum = r_dnum_s2;
    assign o_sod  = r_sod_s2;

endmodule

### rtl/core/ecd_date_calc.sv
// Era, year, month and day from the biased day number.
module ecd_date_calc (
    input  logic                           i_clk,
    input  ecd_pkg::t_stage_en             i_en,
    input  logic [ecd_pkg::DNUM_W-1:0]     i_dnum,
    output logic [ecd_pkg::YEAR_W-1:0]     o_year,
    output logic [ecd_pkg::MONTH_W-1:0]    o_month,
    output logic [ecd_pkg::DAY_W-1:0]      o_day
);
    import ecd_pkg::*;

    logic             r_era5_s3, r_era5_s4, r_era5_s5, r_era5_s6;
    logic [DOE_W-1:0] r_doe_s3, r_doe_s4, r_doe_s5, r_doe_s6;
    logic [6:0]       r_d1460_s4;
    logic [2:0]       r_cent_s4;
    logic             r_last_s4;
    logic [DOE_W-1:0] r_t_s5;
    logic [8:0]       r_yoe_s6;
    logic [8:0]       r_doy_s7, r_doy_s8;
    logic [11:0]      r_yr_s7, r_yr_s8;
    logic [3:0]       r_mp_s8;
    logic [YEAR_W-1:0]  r_year_s9;
    logic [MONTH_W-1:0] r_month_s9;
    logic [DAY_W-1:0]   r_day_s9;

    logic [19:0]      w_dn;
    logic             w_era5;
    logic [DOE_W-1:0] w_doe;
    logic [35:0]      w_prod_1460;
    logic [2:0]       w_cent;
    logic [DOE_W-1:0] w_t;
    logic [35:0]      w_prod_yoe;
    logic [1:0]       w_yoe100;
    logic [DOE_W-1:0] w_base;
    logic [10:0]      w_mx;
    logic [23:0]      w_prod_mp;
    logic [8:0]       w_start;
    logic [3:0]       w_mm;
    logic [11:0]      w_yr_adj;

    // The day count always falls in era four or five.
    assign w_dn   = 20'(i_dnum) + DNUM_OFFSET;
    assign w_era5 = (w_dn >= ERA5_START);
    assign w_doe  = DOE_W'(w_dn - (w_era5 ? ERA5_START : ERA4_START));

    // doe / 1460 is (doe / 4) / 365.
    assign w_prod_1460 = 36'(r_doe_s3[17:2]) * 36'(RECIP_365);

    always_comb begin
        if (r_doe_s3 >= ERA_LAST) begin
            w_cent = 3'd4;
        end else if (r_doe_s3 >= CENT_3) begin
            w_cent = 3'd3;
        end else if (r_doe_s3 >= CENT_2) begin
            w_cent = 3'd2;
        end else if (r_doe_s3 >= CENT_1) begin
            w_cent = 3'd1;
        end else begin
            w_cent = 3'd0;
        end
    end

    assign w_t = r_doe_s4 - DOE_W'(r_d1460_s4) + DOE_W'(r_cent_s4) - DOE_W'(r_last_s4);

    assign w_prod_yoe = 36'(r_t_s5) * 36'(RECIP_365);

    always_comb begin
        if (r_yoe_s6 >= 9'd300) begin
            w_yoe100 = 2'd3;
        end else if (r_yoe_s6 >= 9'd200) begin
            w_yoe100 = 2'd2;
        end else if (r_yoe_s6 >= 9'd100) begin
            w_yoe100 = 2'd1;
        end else begin
            w_yoe100 = 2'd0;
        end
    end

    assign w_base = DOE_W'(r_yoe_s6) * DAYS_PER_YEAR + DOE_W'(r_yoe_s6[8:2])
                  - DOE_W'(w_yoe100);

    // Month index mp = (5 * doy + 2) / 153.
    assign w_mx      = {r_doy_s7, 2'b00} + 11'(r_doy_s7) + 11'd2;
    assign w_prod_mp = 24'(w_mx) * 24'(RECIP_153);

    assign w_start  = month_start(r_mp_s8);
    assign w_mm     = (r_mp_s8 < 4'd10) ? (r_mp_s8 + 4'd3) : (r_mp_s8 - 4'd9);
    // January and February belong to the following calendar year.
    assign w_yr_adj = r_yr_s8 + 12'((w_mm <= 4'd2) ? 1'b1 : 1'b0);

    always_ff @(posedge i_clk) begin
        if (i_en[STG_ERA]) begin
            r_era5_s3 <= w_era5;
            r_doe_s3  <= w_doe;
        end
        if (i_en[STG_LEAP]) begin
            r_era5_s4  <= r_era5_s3;
            r_doe_s4   <= r_doe_s3;
            r_d1460_s4 <= w_prod_1460[32:26];
            r_cent_s4  <= w_cent;
            r_last_s4  <= (r_doe_s3 >= ERA_LAST);
        end
        if (i_en[STG_TRUE]) begin
            r_era5_s5 <= r_era5_s4;
            r_doe_s5  <= r_doe_s4;
            r_t_s5    <= w_t;
        end
        if (i_en[STG_YOE]) begin
            r_era5_s6 <= r_era5_s5;
            r_doe_s6  <= r_doe_s5;
            r_yoe_s6  <= w_prod_yoe[34:26];
        end
        if (i_en[STG_DOY]) begin
            r_doy_s7 <= 9'(r_doe_s6 - w_base);
            r_yr_s7  <= 12'(r_yoe_s6) + (r_era5_s6 ? ERA5_YEAR : ERA4_YEAR);
        end
        if (i_en[STG_MONTH]) begin
            r_doy_s8 <= r_doy_s7;
            r_yr_s8  <= r_yr_s7;
            r_mp_s8  <= w_prod_mp[23:20];
        end
        if (i_en[STG_OUT]) begin
            r_year_s9  <= w_yr_adj[YEAR_W-1:0];
            r_month_s9 <= w_mm;
            r_day_s9   <= DAY_W'(r_doy_s8 - w_start + 9'd1);
        end
    end

    assign o_year  = r_year_s9;
    assign o_month = r_month_s9;
    assign o_day   = r_day_s9;

endmodule

### rtl/core/ecd_time_calc.sv
// Hour, minute and second from the second of day.
module ecd_time_calc (
    input  logic                           i_clk,
    input  ecd_pkg::t_stage_en             i_en,
    input  logic [ecd_pkg::SOD_W-1:0]      i_sod,
    output ecd_pkg::t_hms                  o_hms
);
    import ecd_pkg::*;

    logic [SOD_W-1:0]    r_sod_s3;
    logic [HOUR_W-1:0]   r_hr_s3, r_hr_s4, r_hr_s5;
    logic [11:0]         r_rem_s4, r_rem_s5;
    logic [MINUTE_W-1:0] r_min_s5;
    t_hms                r_hms_s6, r_hms_s7, r_hms_s8, r_hms_s9;

    logic [32:0]      w_prod_hr;
    logic [SOD_W-1:0] w_rem;
    logic [23:0]      w_prod_min;
    logic [11:0]      w_sec;
    t_hms             w_hms;

    assign w_prod_hr  = 33'(i_sod) * 33'(RECIP_3600);
    assign w_rem      = r_sod_s3 - SOD_W'(r_hr_s3) * SECS_PER_HOUR;
    assign w_prod_min = 24'(r_rem_s4) * 24'(RECIP_60);
    assign w_sec      = r_rem_s5 - 12'(r_min_s5) * SECS_PER_MIN;

    always_comb begin
        w_hms.hour   = r_hr_s5;
        w_hms.minute = r_min_s5;
        w_hms.second = w_sec[SECOND_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[STG_ERA]) begin
            r_sod_s3 <= i_sod;
            r_hr_s3  <= w_prod_hr[31:27];
        end
        if (i_en[STG_LEAP]) begin
            r_hr_s4  <= r_hr_s3;
            r_rem_s4 <= w_rem[11:0];
        end
        if (i_en[STG_TRUE]) begin
            r_hr_s5  <= r_hr_s4;
            r_rem_s5 <= r_rem_s4;
            r_min_s5 <= w_prod_min[22:17];
        end
        if (i_en[STG_YOE]) begin
            r_hms_s6 <= w_hms;
        end
        // The time fields wait here for the longer date path.
        if (i_en[STG_DOY]) begin
            r_hms_s7 <= r_hms_s6;
        end
        if (i_en[STG_MONTH]) begin
            r_hms_s8 <= r_hms_s7;
        end
        if (i_en[STG_OUT]) begin
            r_hms_s9 <= r_hms_s8;
        end
    end

    assign o_hms = r_hms_s9;

endmodule

### rtl/core/epoch_seconds_to_civil_date_unit.sv
// Top level of the epoch seconds to civil date and time converter.
//
//  Channel  | Direction | tdata fields, lowest bit first
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | epoch_seconds[31:0] (signed)
//  m_axis   | out       | year[10:0] month[14:11] day[19:15] hour[24:20]
//           |           | minute[30:25] second_of_minute[36:31] zero[39:37]
//
// Each request passes through ten register stages; one request can enter every
// cycle unless back-pressure from m_axis has filled the pipeline. The depth is set
// by the chain of constant-reciprocal multiplies on the date path.
// Reset (synchronous, active low) empties every stage; payload registers are not
// cleared. A stage moves forward when it is empty or the stage after it moves, so
// bubbles close up under a stall and a request is never lost or repeated.
module epoch_seconds_to_civil_date_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // epoch_seconds[31:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // year, month, day, hour, minute, second
);
    import ecd_pkg::*;

    // One valid bit per stage travels alongside the data registers.
    t_stage_en r_valid;
    t_stage_en n_valid;
    t_stage_en w_en;

    logic [DNUM_W-1:0]   w_dnum;
    logic [SOD_W-1:0]    w_sod;
    logic [YEAR_W-1:0]   w_year;
    logic [MONTH_W-1:0]  w_month;
    logic [DAY_W-1:0]    w_day;
    t_hms                w_hms;

    // A stage may load when it is empty or its contents move on this cycle.
    always_comb begin
        w_en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign n_valid = {r_valid[NUM_STAGES-2:0], i_s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= (w_en & n_valid) | (~w_en & r_valid);
        end
    end

    assign o_s_axis_tready = w_en[STG_BIAS];
    assign o_m_axis_tvalid = r_valid[STG_OUT];

    // Seconds split into days and second of day (stages 0 to 2).
    ecd_day_split u_day_split (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_secs (i_s_axis_tdata),
        .o_dnum (w_dnum),
        .o_sod  (w_sod)
    );

    // Calendar date from the day number (stages 3 to 9).
    ecd_date_calc u_date_calc (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dnum  (w_dnum),
        .o_year  (w_year),
        .o_month (w_month),
        .o_day   (w_day)
    );

    // Time of day from the second of day, delayed to line up with the date.
    ecd_time_calc u_time_calc (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_sod (w_sod),
        .o_hms (w_hms)
    );

    assign o_m_axis_tdata = {3'b000, w_hms.second, w_hms.minute, w_hms.hour,
                             w_day, w_month, w_year};

`ifndef SYNTHESIS
    // An accepted request always lands in the first stage.
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_valid[STG_BIAS])
        else $error("accepted request did not enter the first stage");

    // With the output stage empty, the pipeline can always take a request.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[STG_OUT] |-> o_s_axis_tready)
        else $error("input stalled while the output stage is empty");

    // A full pipeline with a stalled output must refuse new requests.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_valid) && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("request accepted into a full stalled pipeline");

    // Every delivered result lies inside the calendar ranges.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[14:11] >= 4'd1 && o_m_axis_tdata[14:11] <= 4'd12
            && o_m_axis_tdata[19:15] >= 5'd1 && o_m_axis_tdata[24:20] <= 5'd23
            && o_m_axis_tdata[30:25] <= 6'd59 && o_m_axis_tdata[36:31] <= 6'd59))
        else $error("result field out of range");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for the epoch seconds to civil date and time converter.
`timescale 1ns / 100ps

module testbench;

    import ecd_pkg::*;

    // Calendar and clock fields of one converted timestamp.
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } t_civil_time;

    // Holds the expected civil times in request order and checks each result.
    class civil_time_scoreboard;
        t_civil_time expected_times[$];
        int unsigned mismatches;
        int unsigned orphans;
        int unsigned dates_checked;

        // Floor-divided day number, then the day count from 0000-03-01 split into
        // 400-year eras, the year of era and a March-based day of year.
        function t_civil_time civil_time_of(logic [31:0] stamp);
            longint      secs;
            longint      days;
            longint      sod;
            int unsigned dn;
            int unsigned era;
            int unsigned doe;
            int unsigned yoe;
            int unsigned yr;
            int unsigned doy;
            int unsigned mp;
            int unsigned dd;
            int unsigned mm;
            t_civil_time t;
            secs = longint'($signed(stamp));
            days = secs / 86400;
            if ((secs % 86400) < 0) begin
                days = days - 1;
            end
            sod = secs - days * 86400;
            dn  = 32'(days + 719468);
            era = dn / 146097;
            doe = dn - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            yr  = yoe + era * 400;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            dd  = doy - (153 * mp + 2) / 5 + 1;
            mm  = (mp < 10) ? mp + 3 : mp - 9;
            if (mm <= 2) begin
                yr = yr + 1;
            end
            t.year   = yr[YEAR_W-1:0];
            t.month  = mm[MONTH_W-1:0];
            t.day    = dd[DAY_W-1:0];
            t.hour   = HOUR_W'(sod / 3600);
            t.minute = MINUTE_W'((sod % 3600) / 60);
            t.second = SECOND_W'(sod % 60);
            return t;
        endfunction

        function void note_timestamp(logic [31:0] stamp);
            expected_times.push_back(civil_time_of(stamp));
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want,
                         got);
            end
        endfunction

        function void check_date(logic [39:0] tdata);
            t_civil_time want;
            if (expected_times.size() == 0) begin
                orphans++;
                $display("%0t: unexpected result, expected nothing, actual tdata 0x%010h",
                         $time, tdata);
                return;
            end
            want = expected_times.pop_front();
            dates_checked++;
            compare_field("year",   want.year,   tdata[10:0]);
            compare_field("month",  want.month,  tdata[14:11]);
            compare_field("day",    want.day,    tdata[19:15]);
            compare_field("hour",   want.hour,   tdata[24:20]);
            compare_field("minute", want.minute, tdata[30:25]);
            compare_field("second", want.second, tdata[36:31]);
            compare_field("padding", 0, tdata[39:37]);
        endfunction

        function int unsigned pending();
            return expected_times.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;     // epoch_seconds[31:0]
    logic        m_valid;
    logic        m_ready;
    logic [39:0] m_data;     // year, month, day, hour, minute, second_of_minute, zero

    civil_time_scoreboard sb;

    // Idle and stall chances in percent; the receiver hold-off counts down in cycles.
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    int unsigned holdoff_left;
    int unsigned requests_sent;

    epoch_seconds_to_civil_date_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // The receiver changes tready at the falling edge. During a hold-off it keeps
    // tready low for a counted number of cycles so that the pipeline fills up and
    // pushes back on the sender.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left > 0) begin
                m_ready <= 1'b0;
                holdoff_left = holdoff_left - 1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Results are taken at the rising edge where tvalid and tready are both high.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            sb.check_date(m_data);
        end
    end

    // Offers one timestamp, possibly after some idle cycles, and holds it until the
    // block takes it. The valid line is written once per falling edge, so a request
    // that follows another right away keeps tvalid high with no dip.
    task automatic send_timestamp(input logic [31:0] stamp);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= stamp;
        do begin
            @(posedge i_clk);
        end while (!(s_valid && s_ready));
        sb.note_timestamp(stamp);
        requests_sent++;
    endtask

    // Random timestamps: a mix of any 32-bit value, instants right around midnight,
    // values near both ends of the range and small offsets around the epoch.
    task automatic send_random_timestamps(input int unsigned count);
        int unsigned pick;
        longint      day_num;
        longint      secs;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                secs = longint'($signed($urandom()));
            end else if (pick < 70) begin
                day_num = longint'($urandom_range(0, 49709)) - 24855;
                secs    = day_num * 86400 + longint'($urandom_range(0, 2)) - 1;
            end else if (pick < 85) begin
                if ($urandom_range(0, 1) == 1) begin
                    secs = 64'sd2147483647 - longint'($urandom_range(0, 200000));
                end else begin
                    secs = -64'sd2147483648 + longint'($urandom_range(0, 200000));
                end
            end else begin
                secs = longint'($urandom_range(0, 2097152)) - 1048576;
            end
            send_timestamp(secs[31:0]);
        end
    endtask

    // Run limit, far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still outstanding", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        sb             = new();
        i_rst_n        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        holdoff_left   = 0;
        requests_sent  = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: epoch, one second either side, midnight crossings before
        // 1970, both ends of the 32-bit range, leap days and year ends.
        send_timestamp(32'h0000_0000);   // 1970-01-01 00:00:00
        send_timestamp(32'hFFFF_FFFF);   // 1969-12-31 23:59:59
        send_timestamp(32'h0000_0001);
        send_timestamp(32'd86399);
        send_timestamp(32'd86400);
        send_timestamp(-32'sd86400);     // 1969-12-31 00:00:00
        send_timestamp(-32'sd86401);     // 1969-12-30 23:59:59
        send_timestamp(32'h7FFF_FFFF);   // 2038-01-19 03:14:07
        send_timestamp(32'h8000_0000);   // 1901-12-13 20:45:52
        send_timestamp(32'h8000_0001);
        send_timestamp(32'h7FFF_FFFE);
        send_timestamp(32'd5097599);     // 1970-02-28 23:59:59
        send_timestamp(32'd5097600);     // 1970-03-01 00:00:00
        send_timestamp(32'd68169600);    // 1972-02-29
        send_timestamp(32'd951782399);   // 2000-02-28 23:59:59
        send_timestamp(32'd951782400);   // 2000-02-29, leap day of a 400-year year
        send_timestamp(32'd951868800);   // 2000-03-01
        send_timestamp(32'd978220800);   // 2000-12-31
        send_timestamp(32'd978307199);   // 2000-12-31 23:59:59
        send_timestamp(32'h5555_5555);
        send_timestamp(32'hAAAA_AAAA);
        send_timestamp(32'hF000_0000);

        // Back pressure: the receiver holds off while requests keep coming.
        holdoff_left = 150;
        send_random_timestamps(100);

        // No idling on either side.
        send_random_timestamps(360);

        // Sender idle most of the time.
        src_idle_pct = 71;
        send_random_timestamps(360);

        // Receiver stalling most of the time.
        src_idle_pct   = 0;
        sink_stall_pct = 71;
        send_random_timestamps(360);

        // Both sides idling now and then.
        src_idle_pct   = 32;
        sink_stall_pct = 32;
        send_random_timestamps(360);

        @(negedge i_clk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (NUM_STAGES * 3) @(posedge i_clk);

        $display("Converted %0d timestamps (%0d results checked) across corner values,",
                 requests_sent, sb.dates_checked);
        $display("midnight crossings, range ends, back pressure and random idling.");
        if (sb.mismatches == 0 && sb.orphans == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
